/* rtl/multi_key_debounce_click_detector_assert.svh */
// Assertion macros for the multi-key debounce and click detector.
`ifndef MULTI_KEY_DEBOUNCE_CLICK_DETECTOR_ASSERT_SVH
`define MULTI_KEY_DEBOUNCE_CLICK_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define MKDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define MKDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mkdc_pkg.sv */
// Shared types and constants of the multi-key debounce and click detector.
`default_nettype none

package mkdc_pkg;

  localparam int unsigned PIN_W   = 4;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned DC_W    = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 8;

  localparam logic [DC_W-1:0] DC_RESET = 8'd5;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLARITY = 2'd0,
    CFG_DEBOUNCE = 2'd1,
    CFG_AUTO     = 2'd2
  } cfg_reg_e;

  // Per-key control for one accepted request.
  typedef struct packed {
    logic scan;  // a tick sample is applied to this key
    logic take;  // the flag is taken and cleared after any scan
  } lane_ctrl_t;

endpackage

`default_nettype wire

/* rtl/mkdc_lane.sv */
// One key's debounce machine: phase, sample counter and click flag.
`default_nettype none

module mkdc_lane #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mkdc_pkg::lane_ctrl_t          ctrl_i,
  input  wire logic                          active_i,
  input  wire logic [mkdc_pkg::DC_W-1:0]     debounce_i,
  output logic                               taken_o
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > mkdc_pkg::DC_W) ? COUNT_WIDTH : mkdc_pkg::DC_W;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic                   flag_q, flag_d, flag_mid;
  logic                   reached;

  // Saturating increment, then compare against the debounce count.
  assign cnt_inc = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + 1'b1;
  assign reached = CMP_W'(cnt_inc) >= CMP_W'(debounce_i);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    flag_mid = flag_q;
    if (ctrl_i.scan) begin
      case (phase_q)
        PH_IDLE: begin
          if (active_i) begin
            cnt_d = cnt_inc;
            if (reached) begin
              phase_d = PH_PRESSED;
              cnt_d   = '0;
            end
          end else begin
            cnt_d = '0;
          end
        end
        PH_PRESSED: begin
          // Active samples leave the release count alone.
          if (!active_i) begin
            cnt_d = cnt_inc;
            if (reached) begin
              phase_d  = PH_RELEASED;
              flag_mid = 1'b1;
              cnt_d    = '0;
            end
          end
        end
        PH_RELEASED: begin
          phase_d = PH_RELEASED;
        end
        default: begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end
      endcase
    end
    taken_o = ctrl_i.take & flag_mid;
    flag_d  = flag_mid & ~ctrl_i.take;
    if (taken_o) begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      flag_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      flag_q  <= flag_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/mkdc_merge.sv */
// Combines the lanes' taken flags into one result and holds it in the output register.
`default_nettype none

module mkdc_merge #(
  parameter int unsigned KEY_COUNT = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              is_tick_i,
  input  wire logic [KEY_COUNT-1:0]              taken_i,
  input  wire logic                              m_ready_i,
  output logic                                   s_ready_o,
  output logic                                   m_valid_o,
  output logic [mkdc_pkg::M_DATA_W-1:0]          m_data_o
);

  logic [mkdc_pkg::PIN_W-1:0]    taken_low;
  logic [mkdc_pkg::PIN_W-1:0]    fired;
  logic                          flag;
  logic                          valid_q, valid_d;
  logic [mkdc_pkg::M_DATA_W-1:0] data_q, data_d;

  // Only keys with a pin bit appear in the reported mask.
  for (genvar i = 0; i < mkdc_pkg::PIN_W; i++) begin : g_low
    if (i < KEY_COUNT) begin : g_key
      assign taken_low[i] = taken_i[i];
    end else begin : g_none
      assign taken_low[i] = 1'b0;
    end
  end

  assign fired = is_tick_i ? taken_low : '0;
  assign flag  = ~is_tick_i & (|taken_i);

  assign s_ready_o = ~valid_q | m_ready_i;

  always_comb begin
    valid_d = valid_q & ~m_ready_i;
    data_d  = data_q;
    if (accept_i) begin
      valid_d = 1'b1;
      data_d  = {{(mkdc_pkg::M_DATA_W - mkdc_pkg::PIN_W - 1){1'b0}}, flag, fired};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

`default_nettype wire

/* rtl/multi_key_debounce_click_detector.sv */
// Top level of the multi-key debounce and click detector.
`default_nettype none
`include "multi_key_debounce_click_detector_assert.svh"

// Debounces KEY_COUNT keys side by side, one lane per key, and latches a click
// flag when a confirmed press is followed by a confirmed release. A request is
// either a scan tick carrying the raw pin levels or a read that takes one key's
// flag. Every accepted request gives exactly one result, which appears in the
// output register on the cycle after acceptance. While the output register is
// empty or downstream is ready, a new request is taken every cycle: the single
// output register is refilled in the same cycle that the downstream side takes
// its contents, so throughput is one request per clock. Configuration writes take
// effect on the next edge and should only be made while no result is pending.
module multi_key_debounce_click_detector #(
  parameter int unsigned KEY_COUNT   = 4,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Request stream.
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [mkdc_pkg::S_DATA_W-1:0]      s_axis_tdata,  // pin_levels[3:0], read_key[7:4]
  input  wire logic                               s_axis_tuser,  // req_type
  // Result stream.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [mkdc_pkg::M_DATA_W-1:0]           m_axis_tdata,  // fired_keys[3:0], flag_out[4]
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [mkdc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [mkdc_pkg::CFG_W-1:0]         cfg_data_i
);

  logic [mkdc_pkg::PIN_W-1:0] pol_q;
  logic [mkdc_pkg::DC_W-1:0]  dc_q;
  logic                       auto_q;

  logic                       accept;
  logic                       is_tick;
  logic [mkdc_pkg::PIN_W-1:0] pins;
  logic [mkdc_pkg::IDX_W-1:0] key_idx;
  logic [KEY_COUNT-1:0]       taken;
  logic [KEY_COUNT-1:0]       active;
  mkdc_pkg::lane_ctrl_t       ctrl [KEY_COUNT];

  logic                       read_acc;
  logic                       tick_acc;
  logic [mkdc_pkg::PIN_W-1:0] res_fired;
  logic                       res_flag;

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign is_tick = (mkdc_pkg::req_e'(s_axis_tuser) == mkdc_pkg::REQ_TICK);
  assign pins    = s_axis_tdata[mkdc_pkg::PIN_W-1:0];
  assign key_idx = s_axis_tdata[mkdc_pkg::PIN_W +: mkdc_pkg::IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q  <= '0;
      dc_q   <= mkdc_pkg::DC_RESET;
      auto_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (mkdc_pkg::cfg_reg_e'(cfg_idx_i))
        mkdc_pkg::CFG_POLARITY: pol_q  <= cfg_data_i[mkdc_pkg::PIN_W-1:0];
        mkdc_pkg::CFG_DEBOUNCE: dc_q   <= cfg_data_i[mkdc_pkg::DC_W-1:0];
        mkdc_pkg::CFG_AUTO:     auto_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    // Keys beyond the pin field see a level and polarity of zero.
    if (k < mkdc_pkg::PIN_W) begin : g_pin
      assign active[k] = pins[k] ^ pol_q[k];
    end else begin : g_nopin
      assign active[k] = 1'b0;
    end

    assign ctrl[k].scan = accept & is_tick;
    assign ctrl[k].take = accept & ((is_tick & auto_q) |
                          (~is_tick & (key_idx == mkdc_pkg::IDX_W'(k))));

    mkdc_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[k]),
      .active_i   (active[k]),
      .debounce_i (dc_q),
      .taken_o    (taken[k])
    );
  end

  mkdc_merge #(
    .KEY_COUNT (KEY_COUNT)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .is_tick_i (is_tick),
    .taken_i   (taken),
    .m_ready_i (m_axis_tready),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata)
  );

  assign read_acc  = accept & ~is_tick;
  assign tick_acc  = accept & is_tick;
  assign res_fired = m_axis_tdata[mkdc_pkg::PIN_W-1:0];
  assign res_flag  = m_axis_tdata[mkdc_pkg::PIN_W];

  `MKDC_ASSERT_NOW(a_read_one_key, read_acc, $onehot0(taken), "read took several keys")
  `MKDC_ASSERT_NEXT(a_read_no_mask, read_acc, m_axis_tvalid && !(|res_fired), "mask on a read")
  `MKDC_ASSERT_NEXT(a_tick_no_flag, tick_acc, m_axis_tvalid && !res_flag, "flag on a tick")
  `MKDC_ASSERT_NEXT(a_manual_no_mask, tick_acc && !auto_q, !(|res_fired), "mask with auto off")

endmodule

`default_nettype wire
